// ===== rtl/nperm9_pkg.sv =====
// ----------------------------------------------------------------------------
// nperm9_pkg
// Types and constants for the next-permutation unit
// ----------------------------------------------------------------------------
package nperm9_pkg;

  localparam int SymbolBits = 4;
  localparam int RowLen     = 9;

  typedef logic [SymbolBits-1:0] sym_t;

  // input item: one row, digit_0 first
  typedef struct packed {
    sym_t digit_0;
    sym_t digit_1;
    sym_t digit_2;
    sym_t digit_3;
    sym_t digit_4;
    sym_t digit_5;
    sym_t digit_6;
    sym_t digit_7;
    sym_t digit_8;
  } row_t;

  // result item
  typedef struct packed {
    sym_t next_0;
    sym_t next_1;
    sym_t next_2;
    sym_t next_3;
    sym_t next_4;
    sym_t next_5;
    sym_t next_6;
    sym_t next_7;
    sym_t next_8;
    logic wrapped;
    logic bad_row;
  } res_t;

  // last row of the cycle and the row it wraps to
  localparam sym_t RowTop [RowLen] = '{
    sym_t'(9), sym_t'(8), sym_t'(7), sym_t'(6), sym_t'(5),
    sym_t'(4), sym_t'(3), sym_t'(2), sym_t'(1)
  };
  localparam sym_t RowFirst [RowLen] = '{
    sym_t'(1), sym_t'(2), sym_t'(3), sym_t'(4), sym_t'(5),
    sym_t'(6), sym_t'(7), sym_t'(8), sym_t'(9)
  };

endpackage

// ===== rtl/next_permutation_9_unit.sv =====
// ----------------------------------------------------------------------------
// next_permutation_9_unit
// Next lexicographic permutation of a nine-symbol row
// ----------------------------------------------------------------------------
// A row is taken whenever start_i is high; busy_o never rises, so one item
// can be sent every clock cycle. Each item is registered on entry, worked
// through one pass of compare, swap and reverse logic, and its result is
// shown on result_o with done_o high for exactly one cycle, out of the
// result register res_q. Results come out in the order rows went in and
// the receiver cannot hold them off, so it must take every strobed result.
// The rate of one item per cycle is set by the two registers that bound the
// nine-symbol permutation network; nothing in the block keeps state from one
// item to the next. A fully descending nine-to-one row wraps to one-to-nine
// with wrapped set; any other row with no ascent comes back unchanged with
// bad_row set.
module next_permutation_9_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  nperm9_pkg::row_t    row_i,
  output logic                done_o,
  output nperm9_pkg::res_t    result_o
);

  localparam int N = nperm9_pkg::RowLen;

  // input register
  logic             valid_q;
  nperm9_pkg::row_t row_q;

  // result register
  logic             done_q;
  nperm9_pkg::res_t res_q;
  nperm9_pkg::res_t res_d;

  // row as an array for the network
  nperm9_pkg::sym_t row [N];
  nperm9_pkg::sym_t nxt [N];
  logic [N-2:0]     asc;
  logic             has_asc;
  logic [2:0]       pivot;
  logic [3:0]       hi;
  nperm9_pkg::sym_t piv_val;
  nperm9_pkg::sym_t hi_val;
  nperm9_pkg::sym_t swp [N];
  logic             is_top;

  // the pipeline never stalls
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= start_i;
      done_q  <= valid_q;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      row_q <= row_i;
    end
    if (valid_q) begin
      res_q <= res_d;
    end
  end

  assign row[0] = row_q.digit_0;
  assign row[1] = row_q.digit_1;
  assign row[2] = row_q.digit_2;
  assign row[3] = row_q.digit_3;
  assign row[4] = row_q.digit_4;
  assign row[5] = row_q.digit_5;
  assign row[6] = row_q.digit_6;
  assign row[7] = row_q.digit_7;
  assign row[8] = row_q.digit_8;

  // rightmost ascent: the pivot
  always_comb begin
    for (int n = 0; n < N - 1; n++) begin
      asc[n] = row[n] < row[n+1];
    end
    has_asc = |asc;
    pivot   = '0;
    for (int n = 0; n < N - 1; n++) begin
      if (asc[n]) begin
        pivot = 3'(n);
      end
    end
  end

  // pivot symbol, then rightmost later symbol above it
  always_comb begin
    piv_val = '0;
    for (int n = 0; n < N - 1; n++) begin
      if (pivot == 3'(n)) begin
        piv_val = row[n];
      end
    end
    hi = 4'(pivot) + 4'd1;
    for (int n = 1; n < N; n++) begin
      if (4'(n) > 4'(pivot) && piv_val < row[n]) begin
        hi = 4'(n);
      end
    end
    hi_val = '0;
    for (int n = 1; n < N; n++) begin
      if (hi == 4'(n)) begin
        hi_val = row[n];
      end
    end
  end

  // swap, then reverse the suffix after the pivot
  always_comb begin
    for (int n = 0; n < N; n++) begin
      if (pivot == 3'(n) && n < N - 1) begin
        swp[n] = hi_val;
      end else if (hi == 4'(n)) begin
        swp[n] = piv_val;
      end else begin
        swp[n] = row[n];
      end
    end
    for (int j = 0; j < N; j++) begin
      nxt[j] = swp[j];
      for (int p = 0; p < j; p++) begin
        if (pivot == 3'(p)) begin
          nxt[j] = swp[p + N - j];
        end
      end
    end
  end

  always_comb begin
    is_top = 1'b1;
    for (int n = 0; n < N; n++) begin
      if (row[n] != nperm9_pkg::RowTop[n]) begin
        is_top = 1'b0;
      end
    end
  end

  always_comb begin
    nperm9_pkg::sym_t out_row [N];
    logic wrap;
    logic bad;
    wrap = 1'b0;
    bad  = 1'b0;
    priority if (has_asc) begin
      out_row = nxt;
    end else if (is_top) begin
      out_row = nperm9_pkg::RowFirst;
      wrap    = 1'b1;
    end else begin
      out_row = row;
      bad     = 1'b1;
    end
    res_d.next_0  = out_row[0];
    res_d.next_1  = out_row[1];
    res_d.next_2  = out_row[2];
    res_d.next_3  = out_row[3];
    res_d.next_4  = out_row[4];
    res_d.next_5  = out_row[5];
    res_d.next_6  = out_row[6];
    res_d.next_7  = out_row[7];
    res_d.next_8  = out_row[8];
    res_d.wrapped = wrap;
    res_d.bad_row = bad;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  // every accepted row gives a result once it has passed row_q and res_q
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result missing two cycles after accept");

  // no result without an accepted row
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result without accepted row");

  // the two flags exclude each other
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.wrapped && result_o.bad_row))
    else $error("wrapped and bad_row both set");

  // a wrap always restarts at the ascending row
  a_wrap_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.wrapped) |->
      (result_o.next_0 == nperm9_pkg::RowFirst[0] &&
       result_o.next_8 == nperm9_pkg::RowFirst[8]))
    else $error("wrapped row is not the first row");
`endif

endmodule
